@@ sv/ets_pkg.sv @@
// Shared types and constants of the tween slot engine.
package ets_pkg;

  localparam int unsigned VIDW      = 6;
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned DIV_STEPS = 16;

  localparam logic [16:0] Q_ONE = 17'h10000;
  localparam logic [17:0] Q_TWO = 18'h20000;

  // operation codes on the input port
  localparam logic [2:0] OPC_SET    = 3'd0;
  localparam logic [2:0] OPC_ADD    = 3'd1;
  localparam logic [2:0] OPC_CANCEL = 3'd2;
  localparam logic [2:0] OPC_TICK   = 3'd3;
  localparam logic [2:0] OPC_QUERY  = 3'd4;

  // easing curve codes
  localparam logic [3:0] CRV_LINEAR    = 4'd0;
  localparam logic [3:0] CRV_QUAD_IN   = 4'd1;
  localparam logic [3:0] CRV_QUAD_OUT  = 4'd2;
  localparam logic [3:0] CRV_QUAD_IO   = 4'd3;
  localparam logic [3:0] CRV_CUBIC_IN  = 4'd4;
  localparam logic [3:0] CRV_CUBIC_OUT = 4'd5;
  localparam logic [3:0] CRV_QUART_IN  = 4'd6;
  localparam logic [3:0] CRV_QUART_OUT = 4'd7;
  localparam logic [3:0] CRV_SMOOTH    = 4'd8;

  typedef enum logic [2:0] {
    OP_SET, OP_ADD, OP_CANCEL, OP_TICK, OP_QUERY, OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    KIND_STATUS, KIND_UPDATE, KIND_DONE, KIND_QUIET
  } kind_e;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_PREP, ST_DROP, ST_ADD, ST_QUERY, ST_DONE, ST_FLUSH,
    ST_TCHK, ST_TORG, ST_TEL, ST_TDIV, ST_TEINI, ST_TMUL, ST_TBL, ST_TSUM, ST_TWR
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [31:0]        now;
    logic [VIDW-1:0]    var_id;
    logic signed [31:0] value;
    logic [31:0]        span;
    logic [31:0]        begin_t;
    logic               started;
    logic [7:0]         mode;
    logic               repl;
  } cmd_t;

  typedef struct packed {
    kind_e              kind;
    logic [VIDW-1:0]    var_id;
    logic signed [31:0] value;
    logic               busy;
    logic [31:0]        rem;
    logic               status;
    logic               last;
  } res_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

endpackage

@@ sv/ets_front.sv @@
// Request decode and command queue in front of the sequencer.
module ets_front #(
  parameter int unsigned VARS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic [2:0]             operation_i,
  input  logic [31:0]            now_time_i,
  input  logic [5:0]             var_id_i,
  input  logic signed [31:0]     value_in_i,
  input  logic [31:0]            span_i,
  input  logic [31:0]            delay_i,
  input  logic [3:0]             curve_i,
  input  logic [3:0]             smooth_power_i,
  input  logic                   replace_old_i,
  output ets_pkg::cmd_t          cmd_o,
  output logic                   cmd_valid_o,
  input  logic                   cmd_pop_i
);

  localparam int unsigned PW = (ets_pkg::CMD_DEPTH > 1) ? $clog2(ets_pkg::CMD_DEPTH) : 1;
  localparam int unsigned NW = $clog2(ets_pkg::CMD_DEPTH + 1);

  ets_pkg::cmd_t cmd_in;
  ets_pkg::cmd_t q_q [ets_pkg::CMD_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [NW-1:0] cnt_q;
  logic [32:0]   begin_sum;
  logic          wr, rd;

  function automatic logic [5:0] var_mod(input logic [5:0] v);
    logic [5:0] r;
    r = '0;
    for (int k = 0; k < 64; k++) begin
      if (v == 6'(k)) r = 6'(k % VARS);
    end
    return r;
  endfunction

  always_comb begin
    unique case (operation_i)
      ets_pkg::OPC_SET:    cmd_in.op = ets_pkg::OP_SET;
      ets_pkg::OPC_ADD:    cmd_in.op = ets_pkg::OP_ADD;
      ets_pkg::OPC_CANCEL: cmd_in.op = ets_pkg::OP_CANCEL;
      ets_pkg::OPC_TICK:   cmd_in.op = ets_pkg::OP_TICK;
      ets_pkg::OPC_QUERY:  cmd_in.op = ets_pkg::OP_QUERY;
      default:             cmd_in.op = ets_pkg::OP_NOP;
    endcase
    begin_sum       = {1'b0, now_time_i} + {1'b0, delay_i};
    cmd_in.now      = now_time_i;
    cmd_in.var_id   = var_mod(var_id_i);
    cmd_in.value    = value_in_i;
    cmd_in.span     = span_i;
    // saturate the start time
    cmd_in.begin_t  = begin_sum[32] ? 32'hFFFF_FFFF : begin_sum[31:0];
    cmd_in.started  = (delay_i == 32'd0);
    cmd_in.mode     = {smooth_power_i, curve_i};
    cmd_in.repl     = replace_old_i;
  end

  assign full_o      = (cnt_q == NW'(ets_pkg::CMD_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_q[rptr_q];
  assign wr          = push_i && !full_o;
  assign rd          = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (wr) q_q[wptr_q] <= cmd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) wptr_q <= (wptr_q == PW'(ets_pkg::CMD_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      if (rd) rptr_q <= (rptr_q == PW'(ets_pkg::CMD_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      cnt_q <= cnt_q + NW'(wr) - NW'(rd);
    end
  end

endmodule

@@ sv/ets_div.sv @@
// Radix-2 restoring divider giving the 16-bit progress fraction.
module ets_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ets_pkg::div_req_t req_i,
  output ets_pkg::div_rsp_t rsp_o
);

  logic        busy_q, done_q;
  logic [3:0]  cnt_q;
  logic [31:0] rem_q, den_q;
  logic [15:0] quo_q;
  logic [32:0] r2;
  logic        ge;

  assign r2 = {rem_q, 1'b0};
  assign ge = (r2 >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      // remainder stays below the divisor
      rem_q <= ge ? 32'(r2 - {1'b0, den_q}) : r2[31:0];
      quo_q <= {quo_q[14:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 4'(ets_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

@@ sv/ets_res_q.sv @@
// Result queue between the sequencer and the output ports.
module ets_res_q (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ets_pkg::res_t data_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output ets_pkg::res_t data_o
);

  localparam int unsigned PW = (ets_pkg::RES_DEPTH > 1) ? $clog2(ets_pkg::RES_DEPTH) : 1;
  localparam int unsigned NW = $clog2(ets_pkg::RES_DEPTH + 1);

  ets_pkg::res_t q_q [ets_pkg::RES_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [NW-1:0] cnt_q;
  logic          wr, rd;

  assign full_o  = (cnt_q == NW'(ets_pkg::RES_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = q_q[rptr_q];
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (wr) q_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) wptr_q <= (wptr_q == PW'(ets_pkg::RES_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      if (rd) rptr_q <= (rptr_q == PW'(ets_pkg::RES_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      cnt_q <= cnt_q + NW'(wr) - NW'(rd);
    end
  end

endmodule

@@ sv/ets_back.sv @@
// Sequencer: slot table, value store, easing and blend datapath.
module ets_back #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned VARS  = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ets_pkg::cmd_t     cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  output logic              clearing_o,
  output ets_pkg::res_t     res_o,
  output logic              res_push_o,
  input  logic              res_full_i,
  output ets_pkg::div_req_t div_req_o,
  input  ets_pkg::div_rsp_t div_rsp_i
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned VW = (VARS > 1) ? $clog2(VARS) : 1;

  ets_pkg::state_e state_q, state_d;
  ets_pkg::cmd_t   cmd_q;
  ets_pkg::res_t   hold_q, hold_new;
  logic            hold_vld_q, hold_load;

  logic [ets_pkg::VIDW-1:0] s_var_q   [SLOTS];
  logic signed [31:0]       s_goal_q  [SLOTS];
  logic signed [31:0]       s_org_q   [SLOTS];
  logic [31:0]              s_beg_q   [SLOTS];
  logic [31:0]              s_span_q  [SLOTS];
  logic [7:0]               s_mode_q  [SLOTS];
  logic [SLOTS-1:0]         s_start_q;
  logic [CW-1:0]            count_q, i_q;

  logic signed [31:0] vmem [VARS];
  logic signed [31:0] rd_q, mem_wd;
  logic [VW-1:0]      rd_addr, mem_wa, clr_q;
  logic               mem_we;

  logic        busy_q, status_q;
  logic [31:0] rem_q;

  logic [15:0]        p_q;
  logic [16:0]        r_q, r_d;
  logic [17:0]        b_q;
  logic               sq_q, sh17_q, add_q, inv_q;
  logic [3:0]         steps_q;
  logic signed [50:0] prod_q;
  logic signed [31:0] nv_q;

  // slot under the cursor
  logic [SW-1:0]      cur;
  logic               in_tab, early, time_up, var_hit, can_emit;
  logic [ets_pkg::VIDW-1:0] c_var;
  logic signed [31:0] c_goal, c_org, nv_fin;
  logic [31:0]        c_beg, c_span, elapsed;
  logic [7:0]         c_mode;
  logic [32:0]        q_end, q_diff;

  logic do_rm, do_add, i_inc, cap_org, q_hit;

  logic [34:0] mprod;
  logic [35:0] msum;
  logic [17:0] my;
  logic [16:0] e_val;
  logic signed [32:0] dlt;
  logic signed [50:0] adj;

  function automatic logic [16:0] int_part(input logic signed [31:0] x);
    logic signed [32:0] a;
    a = {x[31], x} + (x[31] ? 33'sd65535 : 33'sd0);
    return a[32:16];
  endfunction

  assign cur      = i_q[SW-1:0];
  assign in_tab   = (i_q < count_q);
  assign c_var    = s_var_q[cur];
  assign c_goal   = s_goal_q[cur];
  assign c_org    = s_org_q[cur];
  assign c_beg    = s_beg_q[cur];
  assign c_span   = s_span_q[cur];
  assign c_mode   = s_mode_q[cur];
  assign early    = (cmd_q.now < c_beg);
  assign elapsed  = cmd_q.now - c_beg;
  assign time_up  = (elapsed >= c_span);
  assign var_hit  = (c_var == cmd_q.var_id);
  assign can_emit = !hold_vld_q || !res_full_i;
  assign q_end    = {1'b0, c_beg} + {1'b0, c_span};
  assign q_diff   = q_end - {1'b0, cmd_q.now};

  assign clearing_o = (state_q == ets_pkg::ST_CLEAR);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ets_pkg::ST_CLEAR: if (clr_q == VW'(VARS - 1)) state_d = ets_pkg::ST_IDLE;
      ets_pkg::ST_IDLE:  if (cmd_valid_i) state_d = ets_pkg::ST_PREP;
      ets_pkg::ST_PREP: begin
        unique case (cmd_q.op)
          ets_pkg::OP_ADD:    state_d = cmd_q.repl ? ets_pkg::ST_DROP : ets_pkg::ST_ADD;
          ets_pkg::OP_CANCEL: state_d = ets_pkg::ST_DROP;
          ets_pkg::OP_QUERY:  state_d = ets_pkg::ST_QUERY;
          ets_pkg::OP_TICK:   state_d = ets_pkg::ST_TCHK;
          default:            state_d = ets_pkg::ST_DONE;
        endcase
      end
      ets_pkg::ST_DROP: begin
        if (!in_tab) begin
          state_d = (cmd_q.op == ets_pkg::OP_ADD) ? ets_pkg::ST_ADD : ets_pkg::ST_DONE;
        end
      end
      ets_pkg::ST_ADD:   state_d = ets_pkg::ST_DONE;
      ets_pkg::ST_QUERY: if (!in_tab || var_hit) state_d = ets_pkg::ST_DONE;
      ets_pkg::ST_DONE:  state_d = ets_pkg::ST_FLUSH;
      ets_pkg::ST_FLUSH: if (!res_full_i) state_d = ets_pkg::ST_IDLE;
      ets_pkg::ST_TCHK: begin
        if (!in_tab) state_d = ets_pkg::ST_FLUSH;
        else if (!early) state_d = s_start_q[cur] ? ets_pkg::ST_TEL : ets_pkg::ST_TORG;
      end
      ets_pkg::ST_TORG:  state_d = ets_pkg::ST_TEL;
      ets_pkg::ST_TEL: begin
        if (!time_up) state_d = ets_pkg::ST_TDIV;
        else if (can_emit) state_d = ets_pkg::ST_TCHK;
      end
      ets_pkg::ST_TDIV:  if (div_rsp_i.done) state_d = ets_pkg::ST_TEINI;
      ets_pkg::ST_TEINI: state_d = ets_pkg::ST_TMUL;
      ets_pkg::ST_TMUL:  if (steps_q == '0) state_d = ets_pkg::ST_TBL;
      ets_pkg::ST_TBL:   state_d = ets_pkg::ST_TSUM;
      ets_pkg::ST_TSUM:  state_d = ets_pkg::ST_TWR;
      ets_pkg::ST_TWR:   if (can_emit) state_d = ets_pkg::ST_TCHK;
      default:           state_d = ets_pkg::ST_IDLE;
    endcase
  end

  // snap the smooth curve onto the goal once the integer part matches
  always_comb begin
    nv_fin = nv_q;
    if (c_mode[3:0] == ets_pkg::CRV_SMOOTH && int_part(nv_q) == int_part(c_goal)) begin
      nv_fin = c_goal;
    end
  end

  // outputs and datapath controls
  always_comb begin
    cmd_pop_o  = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = VW'(cmd_q.var_id);
    mem_wd     = cmd_q.value;
    rd_addr    = VW'(cmd_q.var_id);
    do_rm      = 1'b0;
    do_add     = 1'b0;
    i_inc      = 1'b0;
    cap_org    = 1'b0;
    q_hit      = 1'b0;
    hold_load  = 1'b0;
    hold_new   = '{kind: ets_pkg::KIND_STATUS, var_id: cmd_q.var_id, value: rd_q,
                   busy: busy_q, rem: rem_q, status: status_q, last: 1'b0};
    res_push_o = 1'b0;
    res_o      = hold_q;
    res_o.last = 1'b0;
    div_req_o  = '{start: 1'b0, num: elapsed, den: c_span};
    unique case (state_q)
      ets_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
      end
      ets_pkg::ST_IDLE: cmd_pop_o = cmd_valid_i;
      ets_pkg::ST_PREP: mem_we = (cmd_q.op == ets_pkg::OP_SET);
      ets_pkg::ST_DROP: begin
        do_rm = in_tab && var_hit;
        i_inc = in_tab && !var_hit;
      end
      ets_pkg::ST_ADD: do_add = (count_q < CW'(SLOTS));
      ets_pkg::ST_QUERY: begin
        q_hit = in_tab && var_hit;
        i_inc = in_tab && !var_hit;
      end
      ets_pkg::ST_DONE: begin
        hold_load = 1'b1;
        if (cmd_q.op == ets_pkg::OP_SET) hold_new.value = cmd_q.value;
      end
      ets_pkg::ST_FLUSH: begin
        res_push_o = !res_full_i;
        res_o.last = 1'b1;
      end
      ets_pkg::ST_TCHK: begin
        rd_addr = VW'(c_var);
        i_inc   = in_tab && early;
        if (!in_tab && !hold_vld_q) begin
          hold_load = 1'b1;
          hold_new  = '{kind: ets_pkg::KIND_QUIET, var_id: '0, value: '0,
                        busy: 1'b0, rem: '0, status: 1'b0, last: 1'b0};
        end
      end
      ets_pkg::ST_TORG: begin
        rd_addr = VW'(c_var);
        cap_org = 1'b1;
      end
      ets_pkg::ST_TEL: begin
        rd_addr = VW'(c_var);
        if (!time_up) begin
          div_req_o.start = 1'b1;
        end else if (can_emit) begin
          mem_we     = 1'b1;
          mem_wa     = VW'(c_var);
          mem_wd     = c_goal;
          do_rm      = 1'b1;
          hold_load  = 1'b1;
          res_push_o = hold_vld_q;
          hold_new   = '{kind: ets_pkg::KIND_DONE, var_id: c_var, value: c_goal,
                         busy: 1'b0, rem: '0, status: 1'b0, last: 1'b0};
        end
      end
      ets_pkg::ST_TWR: begin
        rd_addr = VW'(c_var);
        if (can_emit) begin
          mem_we     = 1'b1;
          mem_wa     = VW'(c_var);
          mem_wd     = nv_fin;
          i_inc      = 1'b1;
          hold_load  = 1'b1;
          res_push_o = hold_vld_q;
          hold_new   = '{kind: ets_pkg::KIND_UPDATE, var_id: c_var, value: nv_fin,
                         busy: 1'b0, rem: '0, status: 1'b0, last: 1'b0};
        end
      end
      default: rd_addr = VW'(c_var);
    endcase
  end

  // shared multiplier for the easing steps: a Q1.16 value times a Q1.16 or Q2.16 factor
  assign my    = sq_q ? {1'b0, r_q} : b_q;
  assign mprod = r_q * my;
  assign msum  = {1'b0, mprod} + (add_q ? 36'h1_0000_0000 : 36'h0);
  assign r_d   = sh17_q ? msum[33:17] : msum[32:16];
  assign e_val = inv_q ? 17'(ets_pkg::Q_ONE - r_q) : r_q;
  assign dlt   = 33'({c_goal[31], c_goal}) - 33'({c_org[31], c_org});
  assign adj   = prod_q + (prod_q[50] ? 51'sd65535 : 51'sd0);

  always_ff @(posedge clk_i) begin
    if (mem_we) vmem[mem_wa] <= mem_wd;
    rd_q <= vmem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
    if (hold_load) hold_q <= hold_new;
    if (state_q == ets_pkg::ST_PREP) begin
      busy_q   <= 1'b0;
      rem_q    <= '0;
      status_q <= 1'b0;
    end
    if (state_q == ets_pkg::ST_ADD) status_q <= !do_add;
    if (q_hit) begin
      busy_q <= 1'b1;
      rem_q  <= (q_end <= {1'b0, cmd_q.now}) ? 32'd0 :
                q_diff[32] ? 32'hFFFF_FFFF : q_diff[31:0];
    end
    if (do_add) begin
      s_var_q[count_q[SW-1:0]]  <= cmd_q.var_id;
      s_goal_q[count_q[SW-1:0]] <= cmd_q.value;
      s_org_q[count_q[SW-1:0]]  <= rd_q;
      s_beg_q[count_q[SW-1:0]]  <= cmd_q.begin_t;
      s_span_q[count_q[SW-1:0]] <= cmd_q.span;
      s_mode_q[count_q[SW-1:0]] <= cmd_q.mode;
    end
    if (cap_org) s_org_q[cur] <= rd_q;
    if (do_rm) begin
      // close the gap: later slots move down one place
      for (int j = 0; j + 1 < SLOTS; j++) begin
        if (SW'(j) >= cur) begin
          s_var_q[j]  <= s_var_q[j+1];
          s_goal_q[j] <= s_goal_q[j+1];
          s_org_q[j]  <= s_org_q[j+1];
          s_beg_q[j]  <= s_beg_q[j+1];
          s_span_q[j] <= s_span_q[j+1];
          s_mode_q[j] <= s_mode_q[j+1];
        end
      end
    end
    if (state_q == ets_pkg::ST_TDIV && div_rsp_i.done) p_q <= div_rsp_i.quot;
    if (state_q == ets_pkg::ST_TEINI) begin
      r_q     <= {1'b0, p_q};
      b_q     <= {2'b0, p_q};
      sq_q    <= 1'b0;
      sh17_q  <= 1'b0;
      add_q   <= 1'b0;
      inv_q   <= 1'b0;
      steps_q <= 4'd0;
      unique case (c_mode[3:0])
        ets_pkg::CRV_QUAD_IN: steps_q <= 4'd1;
        ets_pkg::CRV_QUAD_OUT: begin
          b_q     <= ets_pkg::Q_TWO - {2'b0, p_q};
          steps_q <= 4'd1;
        end
        ets_pkg::CRV_QUAD_IO: begin
          sh17_q  <= 1'b1;
          steps_q <= 4'd1;
          if (!p_q[15]) begin
            r_q <= {p_q, 1'b0};
            b_q <= {1'b0, p_q, 1'b0};
          end else begin
            r_q <= {1'b0, p_q[14:0], 1'b0};
            b_q <= ets_pkg::Q_TWO - {2'b0, p_q[14:0], 1'b0};
            add_q <= 1'b1;
          end
        end
        ets_pkg::CRV_CUBIC_IN: steps_q <= 4'd2;
        ets_pkg::CRV_CUBIC_OUT: begin
          r_q     <= ets_pkg::Q_ONE - {1'b0, p_q};
          b_q     <= {1'b0, 17'(ets_pkg::Q_ONE - {1'b0, p_q})};
          inv_q   <= 1'b1;
          steps_q <= 4'd2;
        end
        ets_pkg::CRV_QUART_IN: begin
          sq_q    <= 1'b1;
          steps_q <= 4'd2;
        end
        ets_pkg::CRV_QUART_OUT: begin
          r_q     <= ets_pkg::Q_ONE - {1'b0, p_q};
          sq_q    <= 1'b1;
          inv_q   <= 1'b1;
          steps_q <= 4'd2;
        end
        ets_pkg::CRV_SMOOTH: begin
          r_q     <= ets_pkg::Q_ONE;
          b_q     <= {1'b0, 17'(ets_pkg::Q_ONE - {1'b0, p_q})};
          inv_q   <= 1'b1;
          steps_q <= c_mode[7:4];
        end
        default: steps_q <= 4'd0;
      endcase
    end
    if (state_q == ets_pkg::ST_TMUL && steps_q != '0) begin
      r_q     <= r_d;
      steps_q <= steps_q - 1'b1;
    end
    if (state_q == ets_pkg::ST_TBL) prod_q <= dlt * $signed({1'b0, e_val});
    if (state_q == ets_pkg::ST_TSUM) nv_q <= c_org + adj[47:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ets_pkg::ST_CLEAR;
      clr_q      <= '0;
      count_q    <= '0;
      i_q        <= '0;
      s_start_q  <= '0;
      hold_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ets_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (cmd_pop_o) i_q <= '0;
      else if (state_q == ets_pkg::ST_PREP) i_q <= '0;
      else if (i_inc) i_q <= i_q + 1'b1;
      if (hold_load) hold_vld_q <= 1'b1;
      else if (res_push_o) hold_vld_q <= 1'b0;
      if (do_add) begin
        count_q <= count_q + 1'b1;
        s_start_q[count_q[SW-1:0]] <= cmd_q.started;
      end
      if (cap_org) s_start_q[cur] <= 1'b1;
      if (do_rm) begin
        count_q <= count_q - 1'b1;
        for (int j = 0; j < SLOTS; j++) begin
          if (SW'(j) >= cur) s_start_q[j] <= (j + 1 < SLOTS) ? s_start_q[(j+1) % SLOTS] : 1'b0;
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(SLOTS))
    else $error("slot count above table size");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_flush_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ets_pkg::ST_FLUSH |-> hold_vld_q)
    else $error("final result missing at flush");

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_o |-> !cmd_pop_o)
    else $error("request taken during value store clear");

  a_rm_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_rm |-> in_tab && !do_add)
    else $error("remove outside the table");

endmodule

@@ sv/eased_tween_slot_engine.sv @@
// Top level of the tween slot engine: request queue, sequencer, divider, result queue.
// After reset the value store is cleared; full stays high meanwhile.
// A tick walks the slots: one not yet begun is skipped, a finished one is set to its goal
// and removed, and any other is divided, eased (up to 15 easing steps) and blended.
// One request is worked at a time; results drain through a 4-entry queue.
module eased_tween_slot_engine #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned VARS  = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         operation_i,
  input  logic [31:0]        now_time_i,
  input  logic [5:0]         var_id_i,
  input  logic signed [31:0] value_in_i,
  input  logic [31:0]        span_i,
  input  logic [31:0]        delay_i,
  input  logic [3:0]         curve_i,
  input  logic [3:0]         smooth_power_i,
  input  logic               replace_old_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind_o,
  output logic [5:0]         var_out_o,
  output logic signed [31:0] value_out_o,
  output logic               busy_res_o,
  output logic [31:0]        remaining_o,
  output logic               status_o,
  output logic               last_o
);

  ets_pkg::cmd_t     cmd;
  ets_pkg::res_t     res_in, res_out;
  ets_pkg::div_req_t div_req;
  ets_pkg::div_rsp_t div_rsp;
  logic cmd_valid, cmd_pop, clearing, front_full, res_push, res_full;

  assign full = front_full || clearing;

  ets_front #(.VARS(VARS)) u_front (
    .clk_i, .rst_ni,
    .push_i(push && !clearing), .full_o(front_full),
    .operation_i, .now_time_i, .var_id_i, .value_in_i, .span_i, .delay_i,
    .curve_i, .smooth_power_i, .replace_old_i,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop)
  );

  ets_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  ets_back #(.SLOTS(SLOTS), .VARS(VARS)) u_back (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop),
    .clearing_o(clearing),
    .res_o(res_in), .res_push_o(res_push), .res_full_i(res_full),
    .div_req_o(div_req), .div_rsp_i(div_rsp)
  );

  ets_res_q u_res_q (
    .clk_i, .rst_ni,
    .push_i(res_push), .data_i(res_in), .full_o(res_full),
    .empty_o(empty), .pop_i(pop), .data_o(res_out)
  );

  assign kind_o      = res_out.kind;
  assign var_out_o   = res_out.var_id;
  assign value_out_o = res_out.value;
  assign busy_res_o  = res_out.busy;
  assign remaining_o = res_out.rem;
  assign status_o    = res_out.status;
  assign last_o      = res_out.last;

endmodule
